FILE: rtl/core/gpr_pkg.sv
`default_nettype none

package gpr_pkg;

  // default grid edge length
  localparam int GRID_SIZE_DEF = 16;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_NEXT,
    S_CHECK,
    S_FINAL,
    S_RESULT
  } state_t;

  // neighbor visiting order around the current cell
  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_RIGHT,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  // write controls for the open and visited maps
  typedef struct packed {
    logic open_we;
    logic open_wd;
    logic vis_we;
    logic vis_wd;
  } map_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/grid_path_reachability.sv
// channel  | signals                                              | handshake
// ---------+------------------------------------------------------+-----------------------
// request  | operation, cell_row, cell_col, cell_open,            | start high, busy low
//          | start_row, start_col, end_row, end_col               |
// result   | reachable                                            | done, one cycle only
//
// a load request writes the open map if the cell is on the grid and busy stays low; it gives no result.
// a query clears the visited map one entry a cycle, then pops each reached
// cell once and tests its four neighbors in turn: each pop, each direction
// step and each lookup of an on-grid neighbor is a state of its own;
// an off-grid query goes straight to the result state and gives its result
// in the cycle after it is taken.
// rst is synchronous and returns the sequencer to idle; the grid contents
// are not cleared. the receiver cannot stall: reachable is valid while done.
`default_nettype none

module grid_path_reachability #(
  parameter int GRID_SIZE = gpr_pkg::GRID_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       operation,
  input  wire logic [3:0] cell_row,
  input  wire logic [3:0] cell_col,
  input  wire logic       cell_open,
  input  wire logic [3:0] start_row,
  input  wire logic [3:0] start_col,
  input  wire logic [3:0] end_row,
  input  wire logic [3:0] end_col,
  output logic            done,
  output logic            reachable
);

  localparam int AW = 2 * $clog2(GRID_SIZE);

  gpr_pkg::map_ctrl_t ctrl;
  logic [AW-1:0]      open_addr;
  logic [AW-1:0]      vis_addr;
  logic               open_rd;
  logic               vis_rd;

  // search sequencer with pending stack
  gpr_ctrl #(
    .GRID_SIZE(GRID_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .cell_open (cell_open),
    .start_row (start_row),
    .start_col (start_col),
    .end_row   (end_row),
    .end_col   (end_col),
    .open_rd   (open_rd),
    .vis_rd    (vis_rd),
    .ctrl      (ctrl),
    .open_addr (open_addr),
    .vis_addr  (vis_addr),
    .busy      (busy),
    .done      (done),
    .reachable (reachable)
  );

  // open and visited cell maps
  gpr_maps #(
    .GRID_SIZE(GRID_SIZE)
  ) u_maps (
    .clk       (clk),
    .ctrl      (ctrl),
    .open_addr (open_addr),
    .vis_addr  (vis_addr),
    .open_rd   (open_rd),
    .vis_rd    (vis_rd)
  );

endmodule

`default_nettype wire

FILE: rtl/core/gpr_maps.sv
`default_nettype none

module gpr_maps #(
  parameter int GRID_SIZE = gpr_pkg::GRID_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire gpr_pkg::map_ctrl_t            ctrl,
  input  wire logic [2*$clog2(GRID_SIZE)-1:0] open_addr,
  input  wire logic [2*$clog2(GRID_SIZE)-1:0] vis_addr,
  output logic                               open_rd,
  output logic                               vis_rd
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 2 ** AW;

  logic open_mem [DEPTH];
  logic vis_mem  [DEPTH];

  // open map: one port, registered read
  always_ff @(posedge clk) begin
    if (ctrl.open_we) begin
      open_mem[open_addr] <= ctrl.open_wd;
    end
    open_rd <= open_mem[open_addr];
  end

  // visited map: one port, registered read
  always_ff @(posedge clk) begin
    if (ctrl.vis_we) begin
      vis_mem[vis_addr] <= ctrl.vis_wd;
    end
    vis_rd <= vis_mem[vis_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/gpr_ctrl.sv
`default_nettype none

module gpr_ctrl #(
  parameter int GRID_SIZE = gpr_pkg::GRID_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           operation,
  input  wire logic [3:0]                     cell_row,
  input  wire logic [3:0]                     cell_col,
  input  wire logic                           cell_open,
  input  wire logic [3:0]                     start_row,
  input  wire logic [3:0]                     start_col,
  input  wire logic [3:0]                     end_row,
  input  wire logic [3:0]                     end_col,
  input  wire logic                           open_rd,
  input  wire logic                           vis_rd,
  output gpr_pkg::map_ctrl_t                  ctrl,
  output logic [2*$clog2(GRID_SIZE)-1:0]      open_addr,
  output logic [2*$clog2(GRID_SIZE)-1:0]      vis_addr,
  output logic                                busy,
  output logic                                done,
  output logic                                reachable
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int AW    = 2 * CW;
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int SA_W  = $clog2(CELLS);
  localparam int TOP_W = $clog2(CELLS + 1);
  localparam logic [CW-1:0]    LAST     = CW'(GRID_SIZE - 1);
  localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(CELLS);

  gpr_pkg::state_t state, state_next;
  gpr_pkg::dir_t   dir, dir_next;

  logic [TOP_W-1:0] top, top_next;
  logic [AW-1:0]    clr_cnt, clr_cnt_next;
  logic [CW-1:0]    s_row, s_col, e_row, e_col;
  logic             off_grid;
  logic [AW-1:0]    nb_addr;

  // pending stack memory
  logic [AW-1:0]    stack_mem [CELLS];
  logic [AW-1:0]    stack_rd;
  logic             stack_we;
  logic [SA_W-1:0]  stack_waddr;
  logic [SA_W-1:0]  stack_raddr;
  logic [AW-1:0]    stack_wd;
  logic [TOP_W-1:0] top_dec;

  // neighbor generation
  logic [CW-1:0] cur_r, cur_c;
  logic [CW-1:0] nb_r, nb_c;
  logic          nb_ok;
  logic [AW-1:0] nb_comb;

  // request decode
  logic take, load_ok, query_off;

  assign take    = start && !busy;
  assign load_ok = ({28'd0, cell_row} < 32'(GRID_SIZE)) &&
                   ({28'd0, cell_col} < 32'(GRID_SIZE));
  assign query_off = !(({28'd0, start_row} < 32'(GRID_SIZE)) &&
                       ({28'd0, start_col} < 32'(GRID_SIZE)) &&
                       ({28'd0, end_row}   < 32'(GRID_SIZE)) &&
                       ({28'd0, end_col}   < 32'(GRID_SIZE)));

  assign top_dec     = top - 1'b1;
  assign stack_raddr = top_dec[SA_W-1:0];
  assign stack_waddr = top[SA_W-1:0];

  // popped cell is held until the next pop
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wd;
    end
    if (state == gpr_pkg::S_POP) begin
      stack_rd <= stack_mem[stack_raddr];
    end
  end

  assign cur_r = stack_rd[AW-1:CW];
  assign cur_c = stack_rd[CW-1:0];

  // one coordinate step and bound check per cycle
  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    case (dir)
      gpr_pkg::DIR_DOWN: begin
        nb_r  = cur_r + 1'b1;
        nb_ok = (cur_r != LAST);
      end
      gpr_pkg::DIR_RIGHT: begin
        nb_c  = cur_c + 1'b1;
        nb_ok = (cur_c != LAST);
      end
      gpr_pkg::DIR_LEFT: begin
        nb_c  = cur_c - 1'b1;
        nb_ok = (cur_c != '0);
      end
      gpr_pkg::DIR_UP: begin
        nb_r  = cur_r - 1'b1;
        nb_ok = (cur_r != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_comb = {nb_r, nb_c};

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gpr_pkg::S_IDLE;
      dir     <= gpr_pkg::DIR_DOWN;
      top     <= '0;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      dir     <= dir_next;
      top     <= top_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  // query coordinates and neighbor address
  always_ff @(posedge clk) begin
    if (take && operation) begin
      s_row    <= CW'(start_row);
      s_col    <= CW'(start_col);
      e_row    <= CW'(end_row);
      e_col    <= CW'(end_col);
      off_grid <= query_off;
    end
    if (state == gpr_pkg::S_NEXT) begin
      nb_addr <= nb_comb;
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    dir_next     = dir;
    top_next     = top;
    clr_cnt_next = clr_cnt;
    ctrl         = '0;
    open_addr    = nb_comb;
    vis_addr     = nb_comb;
    stack_we     = 1'b0;
    stack_wd     = nb_addr;
    busy         = 1'b1;
    done         = 1'b0;
    reachable    = 1'b0;
    case (state)
      gpr_pkg::S_IDLE: begin
        busy      = 1'b0;
        open_addr = {CW'(cell_row), CW'(cell_col)};
        if (take && !operation) begin
          ctrl.open_we = load_ok;
          ctrl.open_wd = cell_open;
        end else if (take) begin
          clr_cnt_next = '0;
          state_next   = query_off ? gpr_pkg::S_RESULT : gpr_pkg::S_CLEAR;
        end
      end
      // wipe the visited map, one entry a cycle
      gpr_pkg::S_CLEAR: begin
        vis_addr     = clr_cnt;
        ctrl.vis_we  = 1'b1;
        ctrl.vis_wd  = 1'b0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == '1) begin
          state_next = gpr_pkg::S_SEED;
        end
      end
      // mark and stack the start cell
      gpr_pkg::S_SEED: begin
        vis_addr    = {s_row, s_col};
        ctrl.vis_we = 1'b1;
        ctrl.vis_wd = 1'b1;
        stack_we    = 1'b1;
        stack_wd    = {s_row, s_col};
        top_next    = top + 1'b1;
        state_next  = gpr_pkg::S_POP;
      end
      gpr_pkg::S_POP: begin
        if (top == '0) begin
          state_next = gpr_pkg::S_FINAL;
        end else begin
          top_next   = top_dec;
          dir_next   = gpr_pkg::DIR_DOWN;
          state_next = gpr_pkg::S_NEXT;
        end
      end
      // look up the neighbor or skip it when off the grid
      gpr_pkg::S_NEXT: begin
        if (nb_ok) begin
          state_next = gpr_pkg::S_CHECK;
        end else if (dir == gpr_pkg::DIR_UP) begin
          state_next = gpr_pkg::S_POP;
        end else begin
          dir_next = gpr_pkg::dir_t'(dir + 2'd1);
        end
      end
      // open and not yet seen: mark and stack it
      gpr_pkg::S_CHECK: begin
        open_addr = nb_addr;
        vis_addr  = nb_addr;
        if (open_rd && !vis_rd) begin
          ctrl.vis_we = 1'b1;
          ctrl.vis_wd = 1'b1;
          if (top != TOP_FULL) begin
            stack_we = 1'b1;
            top_next = top + 1'b1;
          end
        end
        if (dir == gpr_pkg::DIR_UP) begin
          state_next = gpr_pkg::S_POP;
        end else begin
          dir_next   = gpr_pkg::dir_t'(dir + 2'd1);
          state_next = gpr_pkg::S_NEXT;
        end
      end
      gpr_pkg::S_FINAL: begin
        vis_addr   = {e_row, e_col};
        state_next = gpr_pkg::S_RESULT;
      end
      gpr_pkg::S_RESULT: begin
        done       = 1'b1;
        reachable  = !off_grid && vis_rd;
        state_next = gpr_pkg::S_IDLE;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
